@@ rtl/olir_pkg.sv @@
// Shared constants, command codes, state encoding and interface structs for the ordered list.
package olir_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;

   // Widths of the transaction fields on the ports.
   localparam int CMD_W = 2;
   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int CNT_PORT_W = 5;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // One spare bit so that position plus one never wraps.
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_POP    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_GRAB,
      ST_READ,
      ST_WRITE,
      ST_PUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_W-1:0]      waddr;
      logic [DATA_WIDTH-1:0] wdata;
      logic [IDX_W-1:0]      raddr;
   } ram_ctrl_type;

   typedef struct packed {
      logic                  fin;
      logic                  ok;
      logic [DATA_WIDTH-1:0] popped;
      logic                  cnt_inc;
      logic                  cnt_dec;
   } result_type;

endpackage

@@ rtl/olir_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module olir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/olir_seq.sv @@
// Sequencer that moves list entries one at a time through the entry RAM.
module olir_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  olir_pkg::cmd_type             cmd,
   input  logic [olir_pkg::POS_W-1:0]    position,
   input  logic [olir_pkg::VAL_W-1:0]    item,
   input  logic [olir_pkg::CNT_W-1:0]    count,
   input  logic                          slot_free,
   input  logic [olir_pkg::DATA_WIDTH-1:0] rd_data,
   output logic                          busy,
   output olir_pkg::ram_ctrl_type        ram_ctrl,
   output olir_pkg::result_type          result
);
   import olir_pkg::*;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      src_ff, src_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] item_ff, item_in;
   logic [DATA_WIDTH-1:0] popped_ff, popped_in;
   logic                  up_ff, up_in;
   logic                  ok_ff, ok_in;
   cmd_type               op_ff, op_in;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] pos_plus;
   logic [CMP_W-1:0] cnt_ext;
   logic             ins_ok;
   logic             rem_ok;
   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] next_src;

   assign pos_ext  = CMP_W'(position);
   assign pos_plus = pos_ext + CMP_W'(1);
   assign cnt_ext  = CMP_W'(count);
   assign ins_ok   = (pos_ext <= cnt_ext) && (cnt_ext < CMP_W'(CAPACITY));
   assign rem_ok   = pos_ext < cnt_ext;
   assign last_idx = IDX_W'(count - CNT_W'(1));
   // The index adder that advances the source index at each step of a shift.
   assign next_src = up_ff ? (src_ff - IDX_W'(1)) : (src_ff + IDX_W'(1));

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (cmd)
                  CMD_INSERT: begin
                     if (!ins_ok) begin
                        state_in = ST_DONE;
                     end else if (pos_ext == cnt_ext) begin
                        state_in = ST_PUT;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_REMOVE: begin
                     if (rem_ok && (pos_plus < cnt_ext)) begin
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  CMD_POP: begin
                     state_in = (count != '0) ? ST_HEAD : ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_HEAD:  state_in = ST_GRAB;
         ST_GRAB:  state_in = (cnt_ext > CMP_W'(1)) ? ST_READ : ST_DONE;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (up_ff) begin
               state_in = (src_ff == pos_ff) ? ST_PUT : ST_READ;
            end else begin
               state_in = (src_ff == last_idx) ? ST_DONE : ST_READ;
            end
         end
         ST_PUT:   state_in = ST_DONE;
         ST_DONE:  state_in = slot_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Output and datapath logic.
   always_comb begin
      src_in    = src_ff;
      pos_in    = pos_ff;
      item_in   = item_ff;
      popped_in = popped_ff;
      up_in     = up_ff;
      ok_in     = ok_ff;
      op_in     = op_ff;
      busy      = 1'b1;
      ram_ctrl  = '{we: 1'b0, waddr: src_ff, wdata: rd_data, raddr: src_ff};
      result    = '{fin: 1'b0, ok: ok_ff, popped: popped_ff,
                    cnt_inc: ok_ff && (op_ff == CMD_INSERT),
                    cnt_dec: ok_ff && (op_ff != CMD_INSERT)};
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               op_in     = cmd;
               pos_in    = IDX_W'(position);
               item_in   = DATA_WIDTH'(item);
               popped_in = '0;
               up_in     = (cmd == CMD_INSERT);
               src_in    = (cmd == CMD_INSERT) ? last_idx : IDX_W'(pos_plus);
               case (cmd)
                  CMD_INSERT: ok_in = ins_ok;
                  CMD_REMOVE: ok_in = rem_ok;
                  CMD_POP:    ok_in = (count != '0);
                  default:    ok_in = 1'b0;
               endcase
            end
         end
         ST_HEAD: begin
            ram_ctrl.raddr = '0;
         end
         ST_GRAB: begin
            // The head word arrives from the read issued in ST_HEAD, in the cycle before.
            popped_in = rd_data;
            src_in    = IDX_W'(1);
            up_in     = 1'b0;
         end
         ST_READ: begin
            ram_ctrl.raddr = src_ff;
         end
         ST_WRITE: begin
            ram_ctrl.we    = 1'b1;
            ram_ctrl.waddr = up_ff ? (src_ff + IDX_W'(1)) : (src_ff - IDX_W'(1));
            ram_ctrl.wdata = rd_data;
            src_in         = next_src;
         end
         ST_PUT: begin
            ram_ctrl.we    = 1'b1;
            ram_ctrl.waddr = pos_ff;
            ram_ctrl.wdata = item_ff;
         end
         ST_DONE: begin
            result.fin = slot_free;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      pos_ff    <= pos_in;
      item_ff   <= item_in;
      popped_ff <= popped_in;
      up_ff     <= up_in;
      ok_ff     <= ok_in;
      op_ff     <= op_in;
   end

endmodule

@@ rtl/ordered_list_insert_remove.sv @@
// Top level of the ordered list: handshakes, entry count, result register and entry RAM.
// A failed command or a remove of the last entry goes straight to the result; an append
// writes the item first; a shift reads and writes each moved entry in turn, and a pop
// reads the head before its shift. One transaction at a time; the next is taken in the
// cycle after the current result is loaded. Reset clears the entry count, the sequencer
// state and the result valid; RAM is kept.
module ordered_list_insert_remove (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [olir_pkg::CMD_W-1:0]   req_cmd,
   input  logic [olir_pkg::POS_W-1:0]   req_position,
   input  logic [olir_pkg::VAL_W-1:0]   req_item_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [olir_pkg::VAL_W-1:0]   rsp_removed_value,
   output logic [olir_pkg::CNT_PORT_W-1:0] rsp_count,
   output logic                         rsp_is_empty
);
   import olir_pkg::*;

   logic                  busy;
   logic                  start;
   logic                  slot_free;
   ram_ctrl_type          ram_ctrl;
   result_type            result;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff;
   logic [VAL_W-1:0]      rsp_removed_ff;
   logic [CNT_PORT_W-1:0] rsp_count_ff;
   logic                  rsp_is_empty_ff;

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   olir_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd_type'(req_cmd)),
      .position  (req_position),
      .item      (req_item_value),
      .count     (count_ff),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .busy      (busy),
      .ram_ctrl  (ram_ctrl),
      .result    (result)
   );

   olir_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock (clock),
      .we    (ram_ctrl.we),
      .waddr (ram_ctrl.waddr),
      .wdata (ram_ctrl.wdata),
      .raddr (ram_ctrl.raddr),
      .rdata (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (result.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (result.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (result.fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (result.fin) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.fin) begin
         rsp_ok_ff       <= result.ok;
         rsp_removed_ff  <= VAL_W'(result.popped);
         rsp_count_ff    <= CNT_PORT_W'(count_in);
         rsp_is_empty_ff <= (count_in == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_empty      = rsp_is_empty_ff;

endmodule

@@ rtl/olir_checker.sv @@
// Port-level checker for the ordered list and its bind to the top level.
module olir_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [olir_pkg::CMD_W-1:0]   req_cmd,
   input logic [olir_pkg::POS_W-1:0]   req_position,
   input logic [olir_pkg::VAL_W-1:0]   req_item_value,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_ok,
   input logic [olir_pkg::VAL_W-1:0]   rsp_removed_value,
   input logic [olir_pkg::CNT_PORT_W-1:0] rsp_count,
   input logic                         rsp_is_empty
);
   import olir_pkg::*;

   // No result may be pending right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A command in progress holds off the next transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a command is in progress");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_count) <= CAPACITY))
      else $error("count exceeds capacity");

   // Only a successful pop can return a nonzero word.
   a_popped_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_removed_value != '0)) |-> rsp_ok)
      else $error("nonzero removed value on a failed command");

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (.*);
